// File: hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication check failed");

`endif

// File: hw/rtl/lctv_pkg.sv
package lctv_pkg;

	// Defaults for the top-level parameters.
	localparam int NUM_TAPS_DEF     = 8;
	localparam int MAX_DRIVE_DEF    = 21000;
	localparam int MAX_REGEN_DEF    = 10000;
	localparam int MAX_SPEED_DEF    = 20000;

	localparam logic [11:0] FAULT_CODE    = 12'hFFF;
	localparam logic [15:0] FULL_Q15      = 16'd32768;
	localparam logic [24:0] SHARE_QUARTER = 25'd16384;
	localparam logic [24:0] SHARE_LIMIT   = 25'd16777216;
	localparam logic signed [26:0] SHARE_HALF = 27'sd32768;

	// Configuration register indexes.
	localparam logic [2:0] CFG_FRONT_DRIVE = 3'd0;
	localparam logic [2:0] CFG_REAR_DRIVE  = 3'd1;
	localparam logic [2:0] CFG_FRONT_REGEN = 3'd2;
	localparam logic [2:0] CFG_REAR_REGEN  = 3'd3;
	localparam logic [2:0] CFG_FAULT_LIMIT = 3'd4;

	localparam logic [14:0] SCALE_RESET = 15'd16384;
	localparam logic [7:0]  LIMIT_RESET = 8'd25;

	typedef struct packed {
		logic              rate_tick;
		logic [15:0]       accel_fraction;
		logic [15:0]       regen_fraction;
		logic signed [15:0] force_front_left;
		logic signed [15:0] force_front_right;
		logic signed [15:0] force_rear_left;
		logic signed [15:0] force_rear_right;
		logic [11:0]       code_front_left;
		logic [11:0]       code_front_right;
		logic [11:0]       code_rear_left;
		logic [11:0]       code_rear_right;
		logic [3:0]        clamp_flags;
	} in_t;

	typedef struct packed {
		logic              ready_res;
		logic [14:0]       speed_limit_rpm;
		logic signed [15:0] torque_front_left;
		logic signed [15:0] torque_front_right;
		logic signed [15:0] torque_rear_left;
		logic signed [15:0] torque_rear_right;
	} out_t;

	// Commands from the sequencer to the datapath.
	typedef struct packed {
		logic       accept;
		logic       upd_en;
		logic       upd_wr;
		logic [1:0] wheel;
		logic       advance;
		logic       check;
		logic       quarter;
		logic       div_load;
		logic       div_step;
		logic       div_store;
		logic       fallback;
		logic       mul_en;
		logic [2:0] mul_step;
		logic       publish;
	} cmd_t;

	// Status from the datapath to the sequencer.
	typedef struct packed {
		logic ready;
		logic tot_pos;
		logic drive;
		logic out_free;
	} sts_t;

endpackage

// File: hw/rtl/lctv_ctrl.sv
`include "assert_macros.svh"

module lctv_ctrl import lctv_pkg::*; #(
	parameter int NUM_TAPS = NUM_TAPS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_tick,
	output logic in_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	localparam int HW  = $clog2(NUM_TAPS);
	localparam int SW  = 16 + HW;
	localparam int DVW = SW + 16;
	localparam int CW  = $clog2(DVW);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_UPD  = 4'd1;
	localparam logic [3:0] ST_CHK  = 4'd2;
	localparam logic [3:0] ST_DEC  = 4'd3;
	localparam logic [3:0] ST_DIVL = 4'd4;
	localparam logic [3:0] ST_DIVR = 4'd5;
	localparam logic [3:0] ST_DIVS = 4'd6;
	localparam logic [3:0] ST_FB   = 4'd7;
	localparam logic [3:0] ST_MUL  = 4'd8;
	localparam logic [3:0] ST_PUB  = 4'd9;

	logic [3:0]    state_q, state_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic [1:0]    whl_q, whl_d;

	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		whl_d   = whl_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && in_tick) begin
					cmd.accept = 1'b1;
					state_d    = ST_UPD;
					cnt_d      = '0;
				end
			end
			ST_UPD: begin
				cmd.upd_en = 1'b1;
				cmd.upd_wr = cnt_q[0];
				cmd.wheel  = cnt_q[2:1];
				cnt_d      = cnt_q + CW'(1);
				if (cnt_q == CW'(7)) begin
					cmd.advance = 1'b1;
					state_d     = ST_CHK;
				end
			end
			ST_CHK: begin
				cmd.check = 1'b1;
				state_d   = ST_DEC;
			end
			ST_DEC: begin
				if (!sts.ready || (sts.drive && !sts.tot_pos)) begin
					state_d = ST_PUB;
				end else if (!sts.tot_pos) begin
					cmd.quarter = 1'b1;
					cnt_d       = '0;
					state_d     = ST_MUL;
				end else begin
					whl_d   = 2'd0;
					state_d = ST_DIVL;
				end
			end
			ST_DIVL: begin
				cmd.div_load = 1'b1;
				cmd.wheel    = whl_q;
				cnt_d        = '0;
				state_d      = ST_DIVR;
			end
			ST_DIVR: begin
				cmd.div_step = 1'b1;
				cnt_d        = cnt_q + CW'(1);
				if (cnt_q == CW'(DVW - 1)) begin
					state_d = ST_DIVS;
				end
			end
			ST_DIVS: begin
				cmd.div_store = 1'b1;
				cmd.wheel     = whl_q;
				whl_d         = whl_q + 2'd1;
				state_d       = (whl_q == 2'd3) ? ST_FB : ST_DIVL;
			end
			ST_FB: begin
				cmd.fallback = 1'b1;
				cnt_d        = '0;
				state_d      = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul_en   = 1'b1;
				cmd.mul_step = cnt_q[2:0];
				cnt_d        = cnt_q + CW'(1);
				if (cnt_q == CW'(7)) begin
					state_d = ST_PUB;
				end
			end
			ST_PUB: begin
				if (sts.out_free) begin
					cmd.publish = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			whl_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			whl_q   <= whl_d;
		end
	end

	`ASSERT_NXT(a_tick_starts_update, clk, arst_n, cmd.accept, state_q == ST_UPD)
	`ASSERT_IMP(a_publish_needs_slot, clk, arst_n, cmd.publish, sts.out_free)

endmodule

// File: hw/rtl/lctv_dp.sv
`include "assert_macros.svh"

module lctv_dp import lctv_pkg::*; #(
	parameter int NUM_TAPS      = NUM_TAPS_DEF,
	parameter int MAX_DRIVE     = MAX_DRIVE_DEF,
	parameter int MAX_REGEN     = MAX_REGEN_DEF,
	parameter int SPEED_CAP_RPM = MAX_SPEED_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  in_t         in_data,
	input  logic        cfg_valid,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output out_t        out_data,
	output logic        out_valid,
	input  logic        out_stall,
	input  cmd_t        cmd,
	output sts_t        sts
);

	localparam int HW  = $clog2(NUM_TAPS);
	localparam int AW  = HW + 2;
	localparam int SW  = 16 + HW;
	localparam int TW  = SW + 2;
	localparam int DVW = SW + 16;

	logic [14:0] fds_q, rds_q, frs_q, rrs_q;
	logic [7:0]  lim_q;

	logic signed [15:0] frc_q [4];
	logic signed [15:0] hist_mem [4*NUM_TAPS];
	logic signed [15:0] rd_q;
	logic [AW-1:0]      addr;
	logic [HW-1:0]      head_q;
	logic               wrapped_q, primed_q;
	logic signed [SW-1:0] sum_q [4];
	logic [7:0]         fcnt_q [4];
	logic signed [TW-1:0] tot_d, tot_q;
	logic               ready_q, drive_q;
	logic [15:0]        mag_q;
	logic [15:0]        fa, fr;
	logic               fault_ok;

	logic [DVW-1:0]     dvd_q;
	logic [TW-2:0]      rem_q;
	logic [TW-1:0]      trial;
	logic               ge;
	logic signed [SW-1:0] a_sel;
	logic [SW-1:0]      amag;
	logic               dneg_q;
	logic [24:0]        sh_mag_q [4];
	logic               sh_neg_q [4];
	logic signed [25:0] sv [4];
	logic signed [26:0] fsum, rsum;

	logic [31:0]        opa;
	logic [24:0]        opb;
	logic [56:0]        prod_q;
	logic [31:0]        magmax_q, poolf_q, poolr_q;
	logic [2:0]         shw;
	logic [26:0]        tmag;
	logic signed [15:0] tsat;
	logic signed [15:0] tq_q [4];
	logic [14:0]        maxsel, fsc, rsc;

	out_t res_q;
	logic vld_q;

	// Forces saturating pedal fractions.
	assign fa = (in_data.accel_fraction > FULL_Q15) ? FULL_Q15 : in_data.accel_fraction;
	assign fr = (in_data.regen_fraction > FULL_Q15) ? FULL_Q15 : in_data.regen_fraction;

	assign addr = {head_q, cmd.wheel};

	// History memory: one read and one write port, read data registered.
	always_ff @(posedge clk) begin
		if (cmd.upd_en && cmd.upd_wr) begin
			hist_mem[addr] <= frc_q[cmd.wheel];
		end
		rd_q <= hist_mem[addr];
	end

	assign tot_d = TW'(sum_q[0]) + TW'(sum_q[1]) + TW'(sum_q[2]) + TW'(sum_q[3]);

	always_comb begin
		fault_ok = 1'b1;
		for (int w = 0; w < 4; w++) begin
			if (fcnt_q[w] >= lim_q) begin
				fault_ok = 1'b0;
			end
		end
	end

	// Serial restoring divider, one quotient bit per cycle.
	assign a_sel = sum_q[cmd.wheel];
	assign amag  = a_sel[SW-1] ? SW'(-a_sel) : SW'(a_sel);
	assign trial = {rem_q, dvd_q[DVW-1]};
	assign ge    = (trial >= {1'b0, tot_q[TW-2:0]});

	always_comb begin
		for (int w = 0; w < 4; w++) begin
			sv[w] = sh_neg_q[w] ? -$signed({1'b0, sh_mag_q[w]}) : $signed({1'b0, sh_mag_q[w]});
		end
		fsum = 27'(sv[0]) + 27'(sv[1]);
		rsum = 27'(sv[2]) + 27'(sv[3]);
	end

	// Shared multiplier operand selection.
	assign maxsel = drive_q ? 15'(MAX_DRIVE) : 15'(MAX_REGEN);
	assign fsc    = drive_q ? fds_q : frs_q;
	assign rsc    = drive_q ? rds_q : rrs_q;
	assign shw    = cmd.mul_step - 3'd3;

	always_comb begin
		case (cmd.mul_step)
			3'd0: begin
				opa = {16'd0, mag_q};
				opb = {10'd0, maxsel};
			end
			3'd1: begin
				opa = prod_q[31:0];
				opb = {10'd0, fsc};
			end
			3'd2: begin
				opa = magmax_q;
				opb = {10'd0, rsc};
			end
			3'd3, 3'd4: begin
				opa = poolf_q;
				opb = sh_mag_q[shw[1:0]];
			end
			3'd5, 3'd6: begin
				opa = poolr_q;
				opb = sh_mag_q[shw[1:0]];
			end
			default: begin
				opa = '0;
				opb = '0;
			end
		endcase
	end

	assign tmag = prod_q[56:30];
	always_comb begin
		if (sh_neg_q[cmd.mul_step[1:0]]) begin
			tsat = (tmag > 27'd32768) ? 16'sh8000 : 16'(-$signed({1'b0, tmag}));
		end else begin
			tsat = (tmag > 27'd32767) ? 16'sd32767 : $signed(tmag[15:0]);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			frc_q[0] <= in_data.force_front_left;
			frc_q[1] <= in_data.force_front_right;
			frc_q[2] <= in_data.force_rear_left;
			frc_q[3] <= in_data.force_rear_right;
			drive_q  <= (fa >= fr);
			mag_q    <= (fa >= fr) ? (fa - fr) : (fr - fa);
		end
		if (cmd.check) begin
			tot_q <= tot_d;
		end
		if (cmd.div_load) begin
			dvd_q  <= {amag, 16'd0};
			rem_q  <= '0;
			dneg_q <= a_sel[SW-1];
		end else if (cmd.div_step) begin
			dvd_q <= {dvd_q[DVW-2:0], ge};
			rem_q <= ge ? (TW-1)'(trial - {1'b0, tot_q[TW-2:0]}) : trial[TW-2:0];
		end
		if (cmd.quarter || (cmd.fallback && !drive_q &&
			(fsum < SHARE_HALF || rsum > SHARE_HALF))) begin
			for (int w = 0; w < 4; w++) begin
				sh_mag_q[w] <= SHARE_QUARTER;
				sh_neg_q[w] <= 1'b0;
			end
		end else if (cmd.div_store) begin
			sh_mag_q[cmd.wheel] <= (dvd_q > DVW'(SHARE_LIMIT)) ? SHARE_LIMIT : dvd_q[24:0];
			sh_neg_q[cmd.wheel] <= dneg_q;
		end
		if (cmd.mul_en) begin
			prod_q <= 57'(opa) * 57'(opb);
			case (cmd.mul_step)
				3'd1: magmax_q <= prod_q[31:0];
				3'd2: poolf_q  <= prod_q[44:13];
				3'd3: poolr_q  <= prod_q[44:13];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fds_q     <= SCALE_RESET;
			rds_q     <= SCALE_RESET;
			frs_q     <= SCALE_RESET;
			rrs_q     <= SCALE_RESET;
			lim_q     <= LIMIT_RESET;
			head_q    <= '0;
			wrapped_q <= 1'b0;
			primed_q  <= 1'b0;
			ready_q   <= 1'b0;
			vld_q     <= 1'b0;
			for (int w = 0; w < 4; w++) begin
				sum_q[w]  <= '0;
				fcnt_q[w] <= '0;
				tq_q[w]   <= '0;
			end
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					CFG_FRONT_DRIVE: fds_q <= cfg_data[14:0];
					CFG_REAR_DRIVE:  rds_q <= cfg_data[14:0];
					CFG_FRONT_REGEN: frs_q <= cfg_data[14:0];
					CFG_REAR_REGEN:  rrs_q <= cfg_data[14:0];
					CFG_FAULT_LIMIT: lim_q <= cfg_data[7:0];
					default: ;
				endcase
			end
			if (cmd.accept) begin
				for (int w = 0; w < 4; w++) begin
					tq_q[w] <= '0;
				end
				fcnt_q[0] <= (in_data.code_front_left == FAULT_CODE || in_data.clamp_flags[0]) ?
					((fcnt_q[0] == 8'hFF) ? fcnt_q[0] : fcnt_q[0] + 8'd1) : 8'd0;
				fcnt_q[1] <= (in_data.code_front_right == FAULT_CODE || in_data.clamp_flags[1]) ?
					((fcnt_q[1] == 8'hFF) ? fcnt_q[1] : fcnt_q[1] + 8'd1) : 8'd0;
				fcnt_q[2] <= (in_data.code_rear_left == FAULT_CODE || in_data.clamp_flags[2]) ?
					((fcnt_q[2] == 8'hFF) ? fcnt_q[2] : fcnt_q[2] + 8'd1) : 8'd0;
				fcnt_q[3] <= (in_data.code_rear_right == FAULT_CODE || in_data.clamp_flags[3]) ?
					((fcnt_q[3] == 8'hFF) ? fcnt_q[3] : fcnt_q[3] + 8'd1) : 8'd0;
			end
			// Running window sum: drop the oldest sample once the ring has wrapped.
			if (cmd.upd_en && cmd.upd_wr) begin
				sum_q[cmd.wheel] <= sum_q[cmd.wheel]
					- SW'(wrapped_q ? rd_q : 16'sd0) + SW'(frc_q[cmd.wheel]);
			end
			if (cmd.advance) begin
				head_q <= (head_q == HW'(NUM_TAPS - 1)) ? '0 : head_q + HW'(1);
				if (head_q == HW'(NUM_TAPS - 1)) begin
					wrapped_q <= 1'b1;
				end
				if (head_q == HW'(NUM_TAPS - 2)) begin
					primed_q <= 1'b1;
				end
			end
			if (cmd.check) begin
				ready_q <= primed_q && fault_ok;
			end
			if (cmd.mul_en && cmd.mul_step[2]) begin
				tq_q[cmd.mul_step[1:0]] <= tsat;
			end
			if (cmd.publish) begin
				vld_q <= 1'b1;
			end else if (vld_q && !out_stall) begin
				vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.publish) begin
			res_q.ready_res          <= ready_q;
			res_q.speed_limit_rpm    <= (ready_q && drive_q) ? 15'(SPEED_CAP_RPM) : 15'd0;
			res_q.torque_front_left  <= tq_q[0];
			res_q.torque_front_right <= tq_q[1];
			res_q.torque_rear_left   <= tq_q[2];
			res_q.torque_rear_right  <= tq_q[3];
		end
	end

	assign out_data     = res_q;
	assign out_valid    = vld_q;
	assign sts.ready    = ready_q;
	assign sts.tot_pos  = !tot_q[TW-1] && (tot_q != '0);
	assign sts.drive    = drive_q;
	assign sts.out_free = !vld_q || !out_stall;

	`ASSERT_IMP(a_div_positive, clk, arst_n, cmd.div_store, !tot_q[TW-1] && tot_q != '0)
	`ASSERT_IMP(a_not_ready_zero, clk, arst_n, out_valid && !out_data.ready_res,
		out_data.speed_limit_rpm == 15'd0 && out_data.torque_front_left == 16'sd0 &&
		out_data.torque_rear_right == 16'sd0)

endmodule

// File: hw/rtl/load_cell_torque_vectoring.sv
// Channel   | Handshake                      | Payload
// in        | in_valid / in_stall            | in_data (in_t), one request per tick
// out       | out_valid / out_stall          | out_data (out_t), one result per tick
// cfg       | cfg_valid / cfg_ready          | cfg_index, cfg_data
//
// A request with rate_tick low is taken while the sequencer is idle and gives no result.
// A tick request that needs the load shares stalls the input through the history update,
// readiness check, a serial division per wheel and the multiplies before the next accept;
// not-ready ticks and drive with no positive total skip the division and the multiplies,
// and regen with no positive total skips only the division.
// Reset clears sums, counters and registers; the history memory is not cleared, and its
// entries are kept out of the sums until the ring has wrapped once.
// A waiting result sits in the output register; the block holds in_stall until it can post.

module load_cell_torque_vectoring import lctv_pkg::*; #(
	parameter int NUM_TAPS             = NUM_TAPS_DEF,
	parameter int MAX_DRIVE_TORQUE_MNM = MAX_DRIVE_DEF,
	parameter int MAX_REGEN_TORQUE_MNM = MAX_REGEN_DEF,
	parameter int MAX_SPEED_RPM        = MAX_SPEED_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_t         in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_t        out_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	cmd_t cmd;
	sts_t sts;

	// Writes always taken, unchecked; the user must keep the sequencer from reading them mid-write.
	assign cfg_ready = 1'b1;

	// The sequencer walks each tick through history update and readiness check, then as
	// needed through share division and the torque multiplies.
	lctv_ctrl #(
		.NUM_TAPS(NUM_TAPS)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_tick(in_data.rate_tick),
		.in_stall(in_stall),
		.sts(sts),
		.cmd(cmd)
	);

	// The filter taps are all equal, so each filtered force is a scaled window sum
	// and the scale cancels in the load share; the datapath keeps window sums only.
	lctv_dp #(
		.NUM_TAPS(NUM_TAPS),
		.MAX_DRIVE(MAX_DRIVE_TORQUE_MNM),
		.MAX_REGEN(MAX_REGEN_TORQUE_MNM),
		.SPEED_CAP_RPM(MAX_SPEED_RPM)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.in_data(in_data),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.out_data(out_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.cmd(cmd),
		.sts(sts)
	);

endmodule

// File: sim/load_cell_torque_vectoring_tb.sv
module load_cell_torque_vectoring_tb;
	import lctv_pkg::*;

	// The block's build-time constants at their defaults.
	localparam int    TAPS       = NUM_TAPS_DEF;
	localparam longint TAP_Q15   = 32768 / TAPS;
	localparam longint Q30       = 1073741824;
	localparam int    SETTLE     = 250;     // a little more than one tick's latency
	localparam int    CYCLE_CAP  = 3000000;

	// Load shares, in Q16.
	localparam longint SH_QUARTER = 16384;
	localparam longint SH_HALF    = 32768;
	localparam longint SH_LIMIT   = 16777216;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	in_t         in_data;
	logic        out_valid;
	logic        out_stall;
	out_t        out_data;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;

	load_cell_torque_vectoring dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Shadow copy of the block's registers and state.
	logic [14:0]        sc_front_drive, sc_rear_drive, sc_front_regen, sc_rear_regen;
	logic [7:0]         fault_limit;
	logic signed [15:0] hist [4][TAPS];
	int                 head;
	bit                 primed;
	logic [7:0]         fault_cnt [4];

	out_t  torque_q[$];     // expected results, oldest first
	int    n_errors;
	int    n_ticks, n_idle_items, n_results, n_ready, n_regen, n_cfg;
	bit    quiet;           // when set, neither side inserts gaps
	int    burst_left, burst_wheel;
	longint cycles;

	// The block is asynchronous-reset; the shadow state starts from the same values.
	function automatic void model_reset();
		sc_front_drive = SCALE_RESET;
		sc_rear_drive  = SCALE_RESET;
		sc_front_regen = SCALE_RESET;
		sc_rear_regen  = SCALE_RESET;
		fault_limit    = LIMIT_RESET;
		foreach (hist[w, k]) hist[w][k] = '0;
		foreach (fault_cnt[w]) fault_cnt[w] = '0;
		head   = 0;
		primed = 0;
	endfunction

	function automatic longint pedal_q15(logic [15:0] v);
		return (v > FULL_Q15) ? longint'(FULL_Q15) : longint'(v);
	endfunction

	// Torque pool in Q29, cut to Q14, then weighted by a Q16 share and saturated.
	function automatic longint share_torque(longint mag, longint max_mnm, logic [14:0] scale,
			longint share);
		longint pool14, t;
		pool14 = (mag * max_mnm * 4 * longint'(scale)) >>> 15;
		t = (pool14 * share) / Q30;
		if (t > 32767) t = 32767;
		if (t < -32768) t = -32768;
		return t;
	endfunction

	// Advances the shadow state by one request and returns the torque split it causes.
	function automatic bit torque_split(input in_t d, output out_t r);
		longint     filt [4];
		longint     shr [4];
		longint     tq [4];
		longint     total, req;
		logic [11:0] code [4];
		bit         ready;
		r = '0;
		if (!d.rate_tick) return 0;
		hist[0][head] = d.force_front_left;
		hist[1][head] = d.force_front_right;
		hist[2][head] = d.force_rear_left;
		hist[3][head] = d.force_rear_right;
		total = 0;
		for (int w = 0; w < 4; w++) begin
			filt[w] = 0;
			for (int k = 0; k < TAPS; k++)
				filt[w] += longint'(hist[w][(head + k) % TAPS]) * TAP_Q15;
			total += filt[w];
			tq[w] = 0;
		end
		head = (head + 1) % TAPS;
		if (head == TAPS - 1) primed = 1;

		code[0] = d.code_front_left;
		code[1] = d.code_front_right;
		code[2] = d.code_rear_left;
		code[3] = d.code_rear_right;
		ready = primed;
		for (int w = 0; w < 4; w++) begin
			if (code[w] != FAULT_CODE && !d.clamp_flags[w])
				fault_cnt[w] = '0;
			else if (fault_cnt[w] != 8'd255)
				fault_cnt[w]++;
			if (fault_cnt[w] >= fault_limit) ready = 0;
		end

		if (ready) begin
			req = pedal_q15(d.accel_fraction) - pedal_q15(d.regen_fraction);
			for (int w = 0; w < 4; w++) begin
				if (total > 0) begin
					shr[w] = (filt[w] * 65536) / total;
					if (shr[w] > SH_LIMIT) shr[w] = SH_LIMIT;
					if (shr[w] < -SH_LIMIT) shr[w] = -SH_LIMIT;
				end else begin
					shr[w] = SH_QUARTER;
				end
			end
			if (req >= 0) begin
				r.speed_limit_rpm = 15'(MAX_SPEED_DEF);
				if (total > 0) begin
					tq[0] = share_torque(req, MAX_DRIVE_DEF, sc_front_drive, shr[0]);
					tq[1] = share_torque(req, MAX_DRIVE_DEF, sc_front_drive, shr[1]);
					tq[2] = share_torque(req, MAX_DRIVE_DEF, sc_rear_drive, shr[2]);
					tq[3] = share_torque(req, MAX_DRIVE_DEF, sc_rear_drive, shr[3]);
				end
			end else begin
				// Regen only follows the load when the front carries at least half and the rear at most half.
				if (shr[0] + shr[1] < SH_HALF || shr[2] + shr[3] > SH_HALF)
					for (int w = 0; w < 4; w++) shr[w] = SH_QUARTER;
				tq[0] = share_torque(-req, MAX_REGEN_DEF, sc_front_regen, shr[0]);
				tq[1] = share_torque(-req, MAX_REGEN_DEF, sc_front_regen, shr[1]);
				tq[2] = share_torque(-req, MAX_REGEN_DEF, sc_rear_regen, shr[2]);
				tq[3] = share_torque(-req, MAX_REGEN_DEF, sc_rear_regen, shr[3]);
			end
		end
		r.ready_res          = ready;
		r.torque_front_left  = tq[0][15:0];
		r.torque_front_right = tq[1][15:0];
		r.torque_rear_left   = tq[2][15:0];
		r.torque_rear_right  = tq[3][15:0];
		return 1;
	endfunction

	// Mostly short gaps, now and then a long one; none at all in quiet stretches.
	function automatic int pick_gap();
		int p;
		p = $urandom_range(0, 99);
		if (quiet || p < 55) return 0;
		if (p < 90) return $urandom_range(1, 3);
		if (p < 98) return $urandom_range(4, 15);
		return $urandom_range(16, 60);
	endfunction

	// Random request. Most are ticks, half with plausible loads; some carry faults, and now
	// and then one wheel stays faulty for a run long enough to cross the limit.
	function automatic in_t random_request(int fault_pct);
		in_t d;
		logic signed [15:0] f [4];
		int m;
		d = '0;
		d.rate_tick = ($urandom_range(0, 99) < 88);
		m = $urandom_range(0, 9);
		if (m < 4) begin
			d.accel_fraction = 16'($urandom_range(0, 32768));
		end else if (m < 7) begin
			d.regen_fraction = 16'($urandom_range(0, 32768));
		end else if (m < 9) begin
			d.accel_fraction = 16'($urandom_range(0, 65535));
			d.regen_fraction = 16'($urandom_range(0, 65535));
		end else begin
			d.accel_fraction = ($urandom_range(0, 1) != 0) ? 16'd32768 : 16'hFFFF;
			d.regen_fraction = ($urandom_range(0, 1) != 0) ? 16'd0 : 16'd32768;
		end
		m = $urandom_range(0, 9);
		for (int w = 0; w < 4; w++) begin
			if (m < 5)                    // ordinary loads, front heavy half the time
				f[w] = (w < 2 && m < 3) ? 16'($urandom_range(8000, 32767))
					: 16'($urandom_range(0, 12000));
			else if (m < 8)
				f[w] = 16'($urandom_range(0, 65535));
			else if (m < 9)
				f[w] = -$signed(16'($urandom_range(0, 32768)));
			else
				f[w] = ($urandom_range(0, 1) != 0) ? 16'sh7FFF : 16'sh8000;
		end
		d.force_front_left  = f[0];
		d.force_front_right = f[1];
		d.force_rear_left   = f[2];
		d.force_rear_right  = f[3];
		d.code_front_left   = 12'($urandom_range(0, 4094));
		d.code_front_right  = 12'($urandom_range(0, 4094));
		d.code_rear_left    = 12'($urandom_range(0, 4094));
		d.code_rear_right   = 12'($urandom_range(0, 4094));
		for (int w = 0; w < 4; w++) begin
			if ($urandom_range(0, 99) < fault_pct) begin
				if ($urandom_range(0, 1) != 0) d.clamp_flags[w] = 1'b1;
				else if (w == 0) d.code_front_left = FAULT_CODE;
				else if (w == 1) d.code_front_right = FAULT_CODE;
				else if (w == 2) d.code_rear_left = FAULT_CODE;
				else d.code_rear_right = FAULT_CODE;
			end
		end
		if (burst_left == 0 && $urandom_range(0, 199) == 0) begin
			burst_left  = $urandom_range(5, 40);
			burst_wheel = $urandom_range(0, 3);
		end
		if (burst_left != 0 && d.rate_tick) begin
			burst_left--;
			d.clamp_flags[burst_wheel] = 1'b1;
		end
		return d;
	endfunction

	// Offers one request and waits for the block to take it. When known is set the
	// expected result is the typed one; the shadow state advances either way.
	task automatic send_request(in_t d, bit known, out_t typed);
		out_t r;
		int gap;
		gap = pick_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= d;
		do @(posedge clk); while (in_stall);
		if (torque_split(d, r)) begin
			torque_q.push_back(known ? typed : r);
			n_ticks++;
		end else begin
			n_idle_items++;
		end
	endtask

	// One write, then one idle cycle on the register channel.
	task automatic write_reg(logic [2:0] idx, logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
		case (idx)
			CFG_FRONT_DRIVE: sc_front_drive = val[14:0];
			CFG_REAR_DRIVE:  sc_rear_drive = val[14:0];
			CFG_FRONT_REGEN: sc_front_regen = val[14:0];
			CFG_REAR_REGEN:  sc_rear_regen = val[14:0];
			CFG_FAULT_LIMIT: fault_limit = val[7:0];
			default: ;
		endcase
		n_cfg++;
	endtask

	// Registers change only with nothing in flight; a non-tick request does no work, so
	// waiting for the last result suffices, and the SETTLE wait after it is a margin.
	task automatic drain();
		in_valid <= 1'b0;
		while (torque_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_all(logic [15:0] fd, logic [15:0] rd, logic [15:0] fr,
			logic [15:0] rr, logic [15:0] lim);
		drain();
		write_reg(CFG_FRONT_DRIVE, fd);
		write_reg(CFG_REAR_DRIVE, rd);
		write_reg(CFG_FRONT_REGEN, fr);
		write_reg(CFG_REAR_REGEN, rr);
		write_reg(CFG_FAULT_LIMIT, lim);
	endtask

	task automatic random_phase(int count, int fault_pct);
		for (int i = 0; i < count; i++) begin
			if (i % 100 == 0) quiet = ($urandom_range(0, 3) == 0);
			send_request(random_request(fault_pct), 1'b0, '0);
		end
		quiet = 0;
	endtask

	// Directed rows: the stimulus, whether the result is typed in, and that result.
	typedef struct {
		in_t  d;
		bit   known;
		out_t r;
	} row_t;
	row_t plan[$];

	function automatic void add_row(bit tick, logic [15:0] acc, logic [15:0] rgn,
			logic [15:0] fl, logic [15:0] fr, logic [15:0] rl, logic [15:0] rr,
			logic [11:0] code, logic [3:0] clamp, bit known);
		row_t row;
		row.d = '0;
		row.d.rate_tick = tick;
		row.d.accel_fraction = acc;
		row.d.regen_fraction = rgn;
		row.d.force_front_left  = fl;
		row.d.force_front_right = fr;
		row.d.force_rear_left   = rl;
		row.d.force_rear_right  = rr;
		row.d.code_front_left   = code;
		row.d.code_front_right  = code;
		row.d.code_rear_left    = code;
		row.d.code_rear_right   = code;
		row.d.clamp_flags = clamp;
		row.known = known;
		row.r = '0;     // typed rows are all before the filter is primed: all zero
		plan.push_back(row);
	endfunction

	// Out side stalls at random, in runs of the same gap mix as the in side.
	initial begin
		int run;
		out_stall = 1'b0;
		forever begin
			run = pick_gap();
			if (run != 0) begin
				out_stall <= 1'b0;
				repeat (run) @(posedge clk);
			end
			out_stall <= ($urandom_range(0, 2) == 0) && !quiet;
			repeat (1 + pick_gap()) @(posedge clk);
		end
	end

	// Every result is checked against the oldest expectation, field by field.
	always @(posedge clk) begin
		out_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (torque_q.size() == 0) begin
				$error("result with nothing expected: %p", out_data);
				n_errors++;
			end else begin
				e = torque_q.pop_front();
				n_results++;
				if (out_data.ready_res) n_ready++;
				if (out_data.ready_res && out_data.speed_limit_rpm == 0) n_regen++;
				if (out_data.ready_res !== e.ready_res) begin
					$error("ready_res: expected %0d, got %0d", e.ready_res,
						out_data.ready_res);
					n_errors++;
				end
				if (out_data.speed_limit_rpm !== e.speed_limit_rpm) begin
					$error("speed_limit_rpm: expected %0d, got %0d", e.speed_limit_rpm,
						out_data.speed_limit_rpm);
					n_errors++;
				end
				if (out_data.torque_front_left !== e.torque_front_left) begin
					$error("torque_front_left: expected %0d, got %0d",
						e.torque_front_left, out_data.torque_front_left);
					n_errors++;
				end
				if (out_data.torque_front_right !== e.torque_front_right) begin
					$error("torque_front_right: expected %0d, got %0d",
						e.torque_front_right, out_data.torque_front_right);
					n_errors++;
				end
				if (out_data.torque_rear_left !== e.torque_rear_left) begin
					$error("torque_rear_left: expected %0d, got %0d",
						e.torque_rear_left, out_data.torque_rear_left);
					n_errors++;
				end
				if (out_data.torque_rear_right !== e.torque_rear_right) begin
					$error("torque_rear_right: expected %0d, got %0d",
						e.torque_rear_right, out_data.torque_rear_right);
					n_errors++;
				end
			end
		end
	end

	// Watchdog. The slowest correct run is well under a third of this.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_CAP) begin
			$display("timeout with %0d results outstanding", torque_q.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_data   = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		quiet     = 0;
		burst_left = 0;
		model_reset();

		// The first six ticks come before the history is full, so they must give an
		// all-zero, not-ready result whatever the pedals, forces and faults say.
		add_row(0, 16'hFFFF, 16'hFFFF, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 12'hFFF,
			4'hF, 0);
		add_row(1, 16'hFFFF, 0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 0, 0, 1);
		add_row(1, 0, 16'hFFFF, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 12'hFFF, 4'hF, 1);
		add_row(1, 16'd32768, 16'd32768, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 12'hAAA,
			4'h5, 1);
		add_row(1, 16'hFFFF, 16'h8001, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 12'h555,
			4'hA, 1);
		add_row(1, 0, 0, 1000, 1000, 1000, 1000, 12'd100, 0, 1);
		add_row(1, 16'hFFFF, 16'hFFFF, 1000, 1000, 1000, 1000, 12'd100, 0, 1);
		// Primed from here: full drive on an even load, pedals over full, zero request.
		add_row(1, 16'd32768, 0, 1000, 1000, 1000, 1000, 0, 0, 0);
		add_row(1, 16'hFFFF, 0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 0, 0, 0);
		add_row(1, 16'd12345, 16'd12345, 3000, 3000, 3000, 3000, 0, 0, 0);
		// Front-heavy regen follows the load; rear-heavy regen falls back to quarters.
		add_row(1, 0, 16'd32768, 30000, 30000, 2000, 2000, 0, 0, 0);
		add_row(1, 0, 16'hFFFF, 30000, 30000, 2000, 2000, 0, 0, 0);
		add_row(1, 0, 16'd20000, 100, 100, 32767, 32767, 0, 0, 0);
		// A near-cancelling load drives the shares into saturation.
		add_row(1, 16'd32768, 0, 16'h7FFF, 16'h8000, 10, 10, 0, 0, 0);
		add_row(1, 0, 16'd32768, 16'h7FFF, 16'h8000, 10, 10, 0, 0, 0);
		// Pull the total negative: drive gives zero torque, regen splits evenly.
		for (int i = 0; i < 5; i++)
			add_row(1, 16'd30000, 0, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 0, 0, 0);
		add_row(1, 0, 16'd30000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 0, 0, 0);
		// Clamp and converter faults with an ordinary request.
		add_row(1, 16'd16384, 0, 5000, 5000, 5000, 5000, 12'hFFF, 0, 0);
		add_row(1, 16'd16384, 0, 5000, 5000, 5000, 5000, 0, 4'h9, 0);
		add_row(1, 16'd16384, 0, 5000, 5000, 5000, 5000, 12'hFFE, 0, 0);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) send_request(plan[i].d, plan[i].known, plan[i].r);

		// Reset values first, then several register settings, the extremes among them.
		random_phase(400, 2);
		set_all(16'd32767, 16'd32767, 16'd32767, 16'd32767, 16'd255);
		random_phase(400, 3);
		set_all(0, 0, 0, 0, 16'd1);
		write_reg(3'd5, 16'hFFFF);        // unmapped index, must change nothing
		write_reg(3'd7, 16'h1234);
		random_phase(350, 1);
		set_all(16'($urandom_range(0, 32767)), 16'($urandom_range(0, 32767)),
			16'($urandom_range(0, 32767)), 16'($urandom_range(0, 32767)), 16'd3);
		random_phase(350, 4);
		// Upper data bits are dropped; a limit of zero keeps the block never ready.
		set_all(16'hFFFF, 16'h8000, 16'hC000, 16'hFFFF, 16'h0100);
		random_phase(100, 2);
		set_all(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
			16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
			16'($urandom_range(1, 10)));
		random_phase(350, 5);

		drain();
		$display("%0d ticks and %0d idle requests sent, %0d results checked", n_ticks,
			n_idle_items, n_results);
		$display("%0d results ready (%0d regen), %0d register writes", n_ready, n_regen,
			n_cfg);
		if (n_errors == 0 && torque_q.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d mismatches, %0d results never seen", n_errors, torque_q.size());
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
